>>> hdl/tsg_pkg.sv
// tsg_pkg: shared constants, datapath command codes and the control/status
// structs of the transient shaper gain unit. No dependencies.
package tsg_pkg;

   // Frame and sample format
   localparam int CHANNELS    = 4;
   localparam int CH_BITS     = 2;
   localparam int CNT_BITS    = 3;   // holds a channel count 0..CHANNELS and more
   localparam int SAMPLE_BITS = 24;

   // Envelope format: magnitude with ENV_FRAC fraction bits
   localparam int ENV_BITS  = 32;
   localparam int ENV_FRAC  = ENV_BITS - SAMPLE_BITS;
   localparam int COEF_BITS = 16;
   localparam int SUM_BITS  = ENV_BITS + CH_BITS;

   // Amount (Q3.12) and gains (Q4.12)
   localparam int AMT_FRAC   = 12;
   localparam int AMT_BITS   = 15;
   localparam int GAIN_BITS  = 16;
   localparam int GMUL_BITS  = 32;   // Q.24 frame gain
   localparam logic [AMT_BITS-1:0] AMOUNT_ONE = AMT_BITS'(4096);
   localparam logic [AMT_BITS-1:0] AMOUNT_MAX = AMT_BITS'(16384);

   // Divider sizes: the quotient stays below 2^AMT_BITS or is saturated
   localparam int DIV_STEPS = AMT_BITS;
   localparam int REM_BITS  = SUM_BITS + DIV_STEPS - 1;
   localparam int STEP_BITS = 4;

   // Shared multiplier and accumulator
   localparam int MA_BITS  = 33;
   localparam int MB_BITS  = 25;
   localparam int ACC_BITS = MA_BITS + MB_BITS;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FAST_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FAST_RELEASE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_ATTACK  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_RELEASE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TRANS_GAIN   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SUSTAIN_GAIN = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_ACTIVE       = 3'd6;

   // Register reset values
   localparam logic [COEF_BITS-1:0] RST_FAST_ATTACK  = 16'd64189;
   localparam logic [COEF_BITS-1:0] RST_FAST_RELEASE = 16'd64859;
   localparam logic [COEF_BITS-1:0] RST_SLOW_ATTACK  = 16'd65401;
   localparam logic [COEF_BITS-1:0] RST_SLOW_RELEASE = 16'd65502;
   localparam logic [GAIN_BITS-1:0] RST_TRANS_GAIN   = 16'd4096;
   localparam logic [GAIN_BITS-1:0] RST_SUSTAIN_GAIN = 16'd4096;
   localparam logic [CNT_BITS-1:0]  RST_ACTIVE       = 3'd2;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_IN,
      OP_FAST_MUL1,
      OP_FAST_MUL2,
      OP_SLOW_MUL1,
      OP_SLOW_MUL2,
      OP_SLOW_WB,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_AMOUNT,
      OP_GAIN_MUL,
      OP_GAIN_WB,
      OP_OUT_MUL,
      OP_OUT_WB,
      OP_LOAD_OUT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CH_BITS-1:0]  ch;
   } cmd_type;

   typedef struct packed {
      logic [CH_BITS-1:0]  last_ch;   // highest active channel of the frame
   } status_type;

endpackage

>>> hdl/transient_shaper_gain_unit.sv
// Transient shaper gain unit: fast/slow envelope follower, ratio and gain.
// Sequence: fast and slow envelope updates per active channel, divider setup and steps,
// amount, gain, output scaling and hand-off, which sets rsp_valid.
// Flow: one frame at a time; the next frame is taken while a result waits,
// and hand-off of a frame stalls until the output register is free.
// Reset: synchronous; registers to defaults, envelopes to zero, no clearing pass.
module transient_shaper_gain_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_0,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_1,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_2,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_3,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_0,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_1,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_2,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_3,
   output logic [tsg_pkg::AMT_BITS-1:0]             rsp_transient_amount,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tsg_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [tsg_pkg::COEF_BITS-1:0]            csr_data
);

   tsg_pkg::cmd_type    cmd;
   tsg_pkg::status_type status;

   // Register writes are taken every cycle
   assign csr_ready = 1'b1;

   tsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tsg_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .status               (status),
      .req_sample_0         (req_sample_0),
      .req_sample_1         (req_sample_1),
      .req_sample_2         (req_sample_2),
      .req_sample_3         (req_sample_3),
      .rsp_shaped_0         (rsp_shaped_0),
      .rsp_shaped_1         (rsp_shaped_1),
      .rsp_shaped_2         (rsp_shaped_2),
      .rsp_shaped_3         (rsp_shaped_3),
      .rsp_transient_amount (rsp_transient_amount)
   );

endmodule

>>> hdl/tsg_ctrl.sv
// tsg_ctrl: sequencer of the transient shaper gain unit. Steps the datapath
// through envelope updates, division, gain and output scaling. Uses tsg_pkg.
module tsg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tsg_pkg::cmd_type      cmd,
   input  tsg_pkg::status_type   status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F1,
      ST_F2,
      ST_S1,
      ST_S2,
      ST_SWB,
      ST_DIV_INIT,
      ST_DIV,
      ST_AMOUNT,
      ST_GAIN,
      ST_GAIN_WB,
      ST_O1,
      ST_O2,
      ST_FIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [tsg_pkg::CH_BITS-1:0]        ch_ff, ch_in;
   logic [tsg_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = tsg_pkg::OP_NONE;
      cmd.ch       = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = tsg_pkg::OP_LOAD_IN;
               ch_in    = '0;
               state_in = ST_F1;
            end
         end
         ST_F1: begin
            cmd.op   = tsg_pkg::OP_FAST_MUL1;
            state_in = ST_F2;
         end
         ST_F2: begin
            cmd.op   = tsg_pkg::OP_FAST_MUL2;
            state_in = ST_S1;
         end
         ST_S1: begin
            cmd.op   = tsg_pkg::OP_SLOW_MUL1;
            state_in = ST_S2;
         end
         ST_S2: begin
            cmd.op   = tsg_pkg::OP_SLOW_MUL2;
            state_in = ST_SWB;
         end
         ST_SWB: begin
            cmd.op = tsg_pkg::OP_SLOW_WB;
            if (ch_ff == status.last_ch) begin
               state_in = ST_DIV_INIT;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_F1;
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = tsg_pkg::OP_DIV_INIT;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = tsg_pkg::OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == tsg_pkg::STEP_BITS'(tsg_pkg::DIV_STEPS - 1)) begin
               state_in = ST_AMOUNT;
            end
         end
         ST_AMOUNT: begin
            cmd.op   = tsg_pkg::OP_AMOUNT;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.op   = tsg_pkg::OP_GAIN_MUL;
            state_in = ST_GAIN_WB;
         end
         ST_GAIN_WB: begin
            cmd.op   = tsg_pkg::OP_GAIN_WB;
            ch_in    = '0;
            state_in = ST_O1;
         end
         ST_O1: begin
            cmd.op   = tsg_pkg::OP_OUT_MUL;
            state_in = ST_O2;
         end
         ST_O2: begin
            cmd.op = tsg_pkg::OP_OUT_WB;
            if (ch_ff == tsg_pkg::CH_BITS'(tsg_pkg::CHANNELS - 1)) begin
               state_in = ST_FIN;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_O1;
            end
         end
         ST_FIN: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = tsg_pkg::OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/tsg_datapath.sv
// tsg_datapath: configuration registers, envelopes, shared multiplier with
// accumulator, restoring divider and output registers. Uses tsg_pkg.
module tsg_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [tsg_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [tsg_pkg::COEF_BITS-1:0]            csr_data,
   input  tsg_pkg::cmd_type                         cmd,
   output tsg_pkg::status_type                      status,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_0,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_1,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_2,
   input  logic signed [tsg_pkg::SAMPLE_BITS-1:0]   req_sample_3,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_0,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_1,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_2,
   output logic signed [tsg_pkg::SAMPLE_BITS-1:0]   rsp_shaped_3,
   output logic [tsg_pkg::AMT_BITS-1:0]             rsp_transient_amount
);

   localparam int SB  = tsg_pkg::SAMPLE_BITS;
   localparam int EB  = tsg_pkg::ENV_BITS;
   localparam int CB  = tsg_pkg::COEF_BITS;
   localparam int AB  = tsg_pkg::ACC_BITS;
   localparam int RB  = tsg_pkg::REM_BITS;
   localparam int QB  = tsg_pkg::AMT_BITS;
   localparam int SUB = tsg_pkg::SUM_BITS;
   localparam int OUT_SHIFT = 24;
   localparam logic signed [AB-1:0] ENV_ROUND = AB'(1) <<< (CB - 1);
   localparam logic signed [AB-1:0] OUT_ROUND = AB'(1) <<< (OUT_SHIFT - 1);
   localparam logic signed [AB-1:0] SMP_MAX   = (AB'(1) <<< (SB - 1)) - AB'(1);
   localparam logic signed [AB-1:0] SMP_MIN   = -(AB'(1) <<< (SB - 1));

   // Configuration registers
   logic [CB-1:0] fast_att_ff, fast_rel_ff, slow_att_ff, slow_rel_ff;
   logic [tsg_pkg::GAIN_BITS-1:0] trans_gain_ff, sus_gain_ff;
   logic [tsg_pkg::CNT_BITS-1:0]  active_ff;

   // Working state
   logic signed [SB-1:0]   sample_ff [tsg_pkg::CHANNELS];
   logic signed [SB-1:0]   shaped_ff [tsg_pkg::CHANNELS];
   logic signed [SB-1:0]   out_ff    [tsg_pkg::CHANNELS];
   logic [EB-1:0]          env_fast_ff, env_slow_ff;
   logic [SUB-1:0]         sum_fast_ff, sum_slow_ff;
   logic signed [AB-1:0]   acc_ff, acc_in;
   logic signed [tsg_pkg::GMUL_BITS-1:0] gain_ff;
   logic [RB-1:0]          rem_ff, den_ff;
   logic [QB-1:0]          quo_ff;
   logic                   div_sat_ff, div_zero_ff;
   logic [QB-1:0]          amount_ff, amount_in, out_amount_ff;

   // Combinational helpers
   logic [tsg_pkg::CNT_BITS-1:0] active_eff;
   logic signed [SB-1:0]   smp;
   logic [SB-1:0]          smp_abs;
   logic [EB-1:0]          mag, cur_env, new_env;
   logic                   is_slow;
   logic [CB-1:0]          coeff;
   logic [CB:0]            coeff_c;
   logic signed [tsg_pkg::GAIN_BITS:0] gain_diff;
   logic signed [tsg_pkg::MA_BITS-1:0] mul_a;
   logic signed [tsg_pkg::MB_BITS-1:0] mul_b;
   logic signed [AB-1:0]   prod;
   logic signed [AB-1:0]   out_shifted;
   logic signed [SB-1:0]   out_sat;
   logic [QB-1:0]          quo_off;
   logic                   rem_ge;

   // Active channel count, 0 acts as 1 and counts above CHANNELS saturate
   always_comb begin
      active_eff = active_ff;
      if (active_ff == '0) begin
         active_eff = tsg_pkg::CNT_BITS'(1);
      end else if (active_ff > tsg_pkg::CNT_BITS'(tsg_pkg::CHANNELS)) begin
         active_eff = tsg_pkg::CNT_BITS'(tsg_pkg::CHANNELS);
      end
   end
   assign status.last_ch = tsg_pkg::CH_BITS'(active_eff - 1'b1);

   // Sample magnitude and coefficient selection
   assign smp     = sample_ff[cmd.ch];
   assign smp_abs = smp[SB-1] ? (~smp + 1'b1) : smp;
   assign mag     = {smp_abs, {tsg_pkg::ENV_FRAC{1'b0}}};
   assign is_slow = (cmd.op == tsg_pkg::OP_SLOW_MUL1) || (cmd.op == tsg_pkg::OP_SLOW_MUL2);
   assign cur_env = is_slow ? env_slow_ff : env_fast_ff;
   always_comb begin
      if (is_slow) begin
         coeff = (mag > cur_env) ? slow_att_ff : slow_rel_ff;
      end else begin
         coeff = (mag > cur_env) ? fast_att_ff : fast_rel_ff;
      end
   end
   assign coeff_c   = (CB+1)'(1) << CB;
   assign gain_diff = $signed({1'b0, trans_gain_ff}) - $signed({1'b0, sus_gain_ff});
   assign new_env   = acc_ff[EB+CB-1:CB];

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op) inside
         tsg_pkg::OP_FAST_MUL1, tsg_pkg::OP_SLOW_MUL1: begin
            mul_a = $signed(tsg_pkg::MA_BITS'(cur_env));
            mul_b = $signed(tsg_pkg::MB_BITS'(coeff));
         end
         tsg_pkg::OP_FAST_MUL2, tsg_pkg::OP_SLOW_MUL2: begin
            mul_a = $signed(tsg_pkg::MA_BITS'(mag));
            mul_b = $signed(tsg_pkg::MB_BITS'(coeff_c - {1'b0, coeff}));
         end
         tsg_pkg::OP_GAIN_MUL: begin
            mul_a = tsg_pkg::MA_BITS'(gain_diff);
            mul_b = $signed(tsg_pkg::MB_BITS'(amount_ff));
         end
         tsg_pkg::OP_OUT_MUL: begin
            mul_a = tsg_pkg::MA_BITS'(gain_ff);
            mul_b = tsg_pkg::MB_BITS'(smp);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = AB'(mul_a) * AB'(mul_b);

   // Accumulator next value
   always_comb begin
      case (cmd.op) inside
         tsg_pkg::OP_FAST_MUL1, tsg_pkg::OP_SLOW_MUL1: acc_in = prod + ENV_ROUND;
         tsg_pkg::OP_FAST_MUL2, tsg_pkg::OP_SLOW_MUL2: acc_in = acc_ff + prod;
         tsg_pkg::OP_GAIN_MUL:
            acc_in = prod + $signed(AB'({sus_gain_ff, {tsg_pkg::AMT_FRAC{1'b0}}}));
         tsg_pkg::OP_OUT_MUL:                          acc_in = prod + OUT_ROUND;
         default:                                      acc_in = acc_ff;
      endcase
   end

   // Shift (rounded by OUT_ROUND in the accumulator) and saturation of a scaled sample
   always_comb begin
      out_shifted = acc_ff >>> OUT_SHIFT;
      if (out_shifted > SMP_MAX) begin
         out_sat = SMP_MAX[SB-1:0];
      end else if (out_shifted < SMP_MIN) begin
         out_sat = SMP_MIN[SB-1:0];
      end else begin
         out_sat = out_shifted[SB-1:0];
      end
   end

   // Amount from quotient: minus one, clamped to 0..AMOUNT_MAX
   assign rem_ge  = (rem_ff >= den_ff);
   assign quo_off = quo_ff - tsg_pkg::AMOUNT_ONE;
   always_comb begin
      if (div_zero_ff) begin
         amount_in = '0;
      end else if (div_sat_ff) begin
         amount_in = tsg_pkg::AMOUNT_MAX;
      end else if (quo_ff > tsg_pkg::AMOUNT_ONE) begin
         amount_in = (quo_off > tsg_pkg::AMOUNT_MAX) ? tsg_pkg::AMOUNT_MAX : quo_off;
      end else begin
         amount_in = '0;
      end
   end

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_att_ff   <= tsg_pkg::RST_FAST_ATTACK;
         fast_rel_ff   <= tsg_pkg::RST_FAST_RELEASE;
         slow_att_ff   <= tsg_pkg::RST_SLOW_ATTACK;
         slow_rel_ff   <= tsg_pkg::RST_SLOW_RELEASE;
         trans_gain_ff <= tsg_pkg::RST_TRANS_GAIN;
         sus_gain_ff   <= tsg_pkg::RST_SUSTAIN_GAIN;
         active_ff     <= tsg_pkg::RST_ACTIVE;
      end else if (csr_we) begin
         unique case (csr_index)
            tsg_pkg::REG_FAST_ATTACK:  fast_att_ff   <= csr_data;
            tsg_pkg::REG_FAST_RELEASE: fast_rel_ff   <= csr_data;
            tsg_pkg::REG_SLOW_ATTACK:  slow_att_ff   <= csr_data;
            tsg_pkg::REG_SLOW_RELEASE: slow_rel_ff   <= csr_data;
            tsg_pkg::REG_TRANS_GAIN:   trans_gain_ff <= csr_data;
            tsg_pkg::REG_SUSTAIN_GAIN: sus_gain_ff   <= csr_data;
            tsg_pkg::REG_ACTIVE:       active_ff     <= csr_data[tsg_pkg::CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         env_fast_ff <= '0;
         env_slow_ff <= '0;
      end else begin
         if (cmd.op == tsg_pkg::OP_SLOW_MUL1) begin
            env_fast_ff <= new_env;
         end
         if (cmd.op == tsg_pkg::OP_SLOW_WB) begin
            env_slow_ff <= new_env;
         end
      end
   end

   // Payload registers: sums, accumulator, divider, gain and words
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.op)
         tsg_pkg::OP_LOAD_IN: begin
            sample_ff[0] <= req_sample_0;
            sample_ff[1] <= req_sample_1;
            sample_ff[2] <= req_sample_2;
            sample_ff[3] <= req_sample_3;
            sum_fast_ff  <= '0;
            sum_slow_ff  <= '0;
         end
         tsg_pkg::OP_SLOW_MUL1: begin
            sum_fast_ff <= sum_fast_ff + SUB'(new_env);
         end
         tsg_pkg::OP_SLOW_WB: begin
            sum_slow_ff <= sum_slow_ff + SUB'(new_env);
         end
         tsg_pkg::OP_DIV_INIT: begin
            rem_ff      <= RB'({sum_fast_ff, {tsg_pkg::AMT_FRAC{1'b0}}});
            den_ff      <= {sum_slow_ff, {(tsg_pkg::DIV_STEPS - 1){1'b0}}};
            quo_ff      <= '0;
            div_zero_ff <= (sum_slow_ff == '0);
            div_sat_ff  <= ((SUB+3)'(sum_fast_ff) >= {sum_slow_ff, 3'b000});
         end
         tsg_pkg::OP_DIV_STEP: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - den_ff;
            end
            quo_ff <= {quo_ff[QB-2:0], rem_ge};
            den_ff <= den_ff >> 1;
         end
         tsg_pkg::OP_AMOUNT: begin
            amount_ff <= amount_in;
         end
         tsg_pkg::OP_GAIN_WB: begin
            gain_ff <= acc_ff[tsg_pkg::GMUL_BITS-1:0];
         end
         tsg_pkg::OP_OUT_WB: begin
            if ({1'b0, cmd.ch} < active_eff) begin
               shaped_ff[cmd.ch] <= out_sat;
            end else begin
               shaped_ff[cmd.ch] <= '0;
            end
         end
         tsg_pkg::OP_LOAD_OUT: begin
            out_ff        <= shaped_ff;
            out_amount_ff <= amount_ff;
         end
         default: ;
      endcase
   end

   assign rsp_shaped_0         = out_ff[0];
   assign rsp_shaped_1         = out_ff[1];
   assign rsp_shaped_2         = out_ff[2];
   assign rsp_shaped_3         = out_ff[3];
   assign rsp_transient_amount = out_amount_ff;

endmodule
